>>> rtl/acmm_pkg.sv
package acmm_pkg;

   // Default sizes of the mix matrix
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 24;
   localparam int COEF_BITS_DEF    = 16;

   // Fixed field widths
   localparam int CFG_W     = 5;    // channel count registers
   localparam int CH_IDX_W  = 4;    // coefficient row / column and output channel index
   localparam int CMP_W     = 6;    // wide enough for any channel count up to 32
   localparam int COEF_AW   = 2 * CH_IDX_W;
   localparam int COEF_DEPTH = 1 << COEF_AW;
   localparam int OUT_MAX   = 1 << CH_IDX_W;

   // Request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_IN_CHANNELS  = 1'b0,
      CSR_OUT_CHANNELS = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } state_type;

endpackage

>>> rtl/acmm_if.sv
interface acmm_req_if #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16
);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [3:0]                    coef_row;
   logic [3:0]                    coef_col;
   logic signed [COEF_BITS-1:0]   coef_value;

   modport source (output valid, req_type, sample, coef_row, coef_col, coef_value,
                   input ready);
   modport sink   (input valid, req_type, sample, coef_row, coef_col, coef_value,
                   output ready);
endinterface

interface acmm_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_sample;
   logic [3:0]                    out_channel;
   logic                          saturated;
   logic                          last;

   modport source (output valid, out_sample, out_channel, saturated, last, input ready);
   modport sink   (input valid, out_sample, out_channel, saturated, last, output ready);
endinterface

>>> rtl/audio_channel_mix_matrix_unit.sv
// A sample that completes a frame starts the mix: each output row reads one frame-buffer
// word and one coefficient per column through the registered read, multiply and
// accumulate stages, and a row's first column waits until the previous result is taken;
// the single frame-buffer / coefficient read port feeds one multiply-accumulate.
// Reset (synchronous, active high): control idle, both channel counts 2, frame restarted,
// every coefficient reads as zero; frame buffer contents stay undefined until written.
module audio_channel_mix_matrix_unit #(
   parameter int MAX_CHANNELS = acmm_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = acmm_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS    = acmm_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   acmm_req_if.sink                      req,
   acmm_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  acmm_pkg::csr_idx_type         csr_index,
   input  logic [acmm_pkg::CFG_W-1:0]    csr_wdata
);
   import acmm_pkg::*;

   // Derived sizes
   localparam int CNT_W     = $clog2(MAX_CHANNELS + 1);
   localparam int FB_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int COEF_FRAC = COEF_BITS - 2;
   localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W     = PROD_W + CNT_W + 1;
   localparam int RND_W     = ACC_W + 1;
   localparam int NOUT_MAX  = (MAX_CHANNELS < OUT_MAX) ? MAX_CHANNELS : OUT_MAX;
   localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [RND_W-1:0] SMAX = (RND_W'(1) <<< (SAMPLE_BITS - 1)) - RND_W'(1);
   localparam logic signed [RND_W-1:0] SMIN = -SMAX - RND_W'(1);

   // Configuration registers
   logic [CFG_W-1:0] in_channels_ff, in_channels_in;
   logic [CFG_W-1:0] out_channels_ff, out_channels_in;

   // Sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] in_index_ff, in_index_in;
   logic [3:0]       row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;

   // Memories
   logic signed [SAMPLE_BITS-1:0] fb_mem [MAX_CHANNELS];
   logic signed [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
   logic [COEF_DEPTH-1:0]         coef_vld_ff;

   // Pipeline
   logic signed [SAMPLE_BITS-1:0] fb_rd_ff;
   logic signed [COEF_BITS-1:0]   coef_rd_ff;
   logic                          coef_ok_ff;
   logic                          p1_vld_ff, p1_first_ff, p1_last_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          p2_vld_ff, p2_first_ff, p2_last_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic                          p3_last_ff;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [3:0]                    rsp_channel_ff;
   logic                          rsp_sat_ff;
   logic                          rsp_last_ff;

   // Combinational
   logic [CMP_W-1:0]       cfg_in_w, nin_w, col_w;
   logic [CNT_W-1:0]       nin, nin_m1, idx_eff, idx_nxt;
   logic [CFG_W-1:0]       cfg_out_w, nout, nout_m1;
   logic                   req_fire, sample_fire, coef_fire, frame_done;
   logic                   coef_addr_ok, col_ok, issue, col_last, row_last;
   logic [COEF_AW-1:0]     coef_waddr, coef_raddr;
   logic signed [COEF_BITS-1:0] coef_eff;
   logic signed [RND_W-1:0] rnd, y;
   logic signed [SAMPLE_BITS-1:0] y_clip;
   logic                   y_sat;

   // Effective channel counts: zero acts as one, clip to the supported maximum
   always_comb begin
      cfg_in_w = CMP_W'(in_channels_ff);
      if (cfg_in_w == '0) begin
         nin_w = CMP_W'(1);
      end else if (cfg_in_w > CMP_W'(MAX_CHANNELS)) begin
         nin_w = CMP_W'(MAX_CHANNELS);
      end else begin
         nin_w = cfg_in_w;
      end
      nin    = nin_w[CNT_W-1:0];
      nin_m1 = nin - CNT_W'(1);

      cfg_out_w = out_channels_ff;
      if (cfg_out_w == '0) begin
         nout = CFG_W'(1);
      end else if (cfg_out_w > CFG_W'(NOUT_MAX)) begin
         nout = CFG_W'(NOUT_MAX);
      end else begin
         nout = cfg_out_w;
      end
      nout_m1 = nout - CFG_W'(1);
   end

   // Request decode
   assign req_fire    = req.valid && req.ready;
   assign sample_fire = req_fire && (req.req_type == REQ_SAMPLE);
   assign coef_fire   = req_fire && (req.req_type == REQ_COEF);

   // Frame position: an index left out of range by a smaller count restarts the frame
   assign idx_eff    = (in_index_ff >= nin) ? '0 : in_index_ff;
   assign idx_nxt    = idx_eff + CNT_W'(1);
   assign frame_done = (idx_nxt == nin);

   // Drop coefficient writes outside the matrix
   assign coef_addr_ok = (CMP_W'(req.coef_row) < CMP_W'(MAX_CHANNELS)) &&
                         (CMP_W'(req.coef_col) < CMP_W'(MAX_CHANNELS));
   assign coef_waddr   = {req.coef_row, req.coef_col};

   // Read side: columns beyond the coefficient matrix weigh zero
   assign col_w      = CMP_W'(col_ff);
   assign col_ok     = (col_w < CMP_W'(OUT_MAX));
   assign coef_raddr = {row_ff, col_w[CH_IDX_W-1:0]};
   assign col_last   = (col_ff == nin_m1);
   assign row_last   = (CFG_W'(row_ff) == nout_m1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_fire && frame_done) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (issue && col_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (p3_last_ff) begin
               state_in = row_last ? ST_IDLE : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs and counters
   always_comb begin
      req.ready   = 1'b0;
      issue       = 1'b0;
      row_in      = row_ff;
      col_in      = col_ff;
      in_index_in = in_index_ff;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (sample_fire) begin
               in_index_in = frame_done ? '0 : idx_nxt;
               row_in      = '0;
               col_in      = '0;
            end
         end
         ST_ISSUE: begin
            // hold the first column of a row until the result slot is empty
            issue = (col_ff != '0) || !rsp_valid_ff;
            if (issue) begin
               col_in = col_last ? '0 : col_ff + CNT_W'(1);
            end
         end
         ST_WAIT: begin
            if (p3_last_ff && !row_last) begin
               row_in = row_ff + 4'd1;
            end
         end
         default: begin
            issue = 1'b0;
         end
      endcase
      // a register write restarts the frame
      if (csr_we) begin
         in_index_in = '0;
      end
   end

   // Configuration writes
   always_comb begin
      in_channels_in  = in_channels_ff;
      out_channels_in = out_channels_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IN_CHANNELS:  in_channels_in  = csr_wdata;
            CSR_OUT_CHANNELS: out_channels_in = csr_wdata;
            default: begin
               in_channels_in  = in_channels_ff;
               out_channels_in = out_channels_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         in_channels_ff  <= CFG_W'(2);
         out_channels_ff <= CFG_W'(2);
         in_index_ff     <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         in_channels_ff  <= in_channels_in;
         out_channels_ff <= out_channels_in;
         in_index_ff     <= in_index_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
      end
   end

   // Frame buffer: write on sample, read the current column
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         fb_mem[idx_eff[FB_AW-1:0]] <= req.sample;
      end
      fb_rd_ff <= fb_mem[col_ff[FB_AW-1:0]];
   end

   // Coefficient store: never-written entries read as zero through their valid bit
   always_ff @(posedge clock) begin
      if (coef_fire && coef_addr_ok) begin
         coef_mem[coef_waddr] <= req.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         coef_ok_ff  <= 1'b0;
      end else begin
         if (coef_fire && coef_addr_ok) begin
            coef_vld_ff[coef_waddr] <= 1'b1;
         end
         coef_ok_ff <= coef_vld_ff[coef_raddr] && col_ok;
      end
   end

   // Multiply
   assign coef_eff = coef_ok_ff ? coef_rd_ff : '0;
   assign prod_in  = PROD_W'(fb_rd_ff) * PROD_W'(coef_eff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (p2_vld_ff) begin
         acc_ff <= (p2_first_ff ? '0 : acc_ff) + ACC_W'(prod_ff);
      end
   end

   // Pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff   <= 1'b0;
         p1_first_ff <= 1'b0;
         p1_last_ff  <= 1'b0;
         p2_vld_ff   <= 1'b0;
         p2_first_ff <= 1'b0;
         p2_last_ff  <= 1'b0;
         p3_last_ff  <= 1'b0;
      end else begin
         p1_vld_ff   <= issue;
         p1_first_ff <= (col_ff == '0);
         p1_last_ff  <= col_last;
         p2_vld_ff   <= p1_vld_ff;
         p2_first_ff <= p1_first_ff;
         p2_last_ff  <= p1_last_ff;
         p3_last_ff  <= p2_vld_ff && p2_last_ff;
      end
   end

   // Round half up to Q1.23, then clip
   always_comb begin
      rnd = RND_W'(acc_ff) + HALF;
      y   = rnd >>> COEF_FRAC;
      if (y > SMAX) begin
         y_clip = SAMPLE_BITS'(SMAX);
         y_sat  = 1'b1;
      end else if (y < SMIN) begin
         y_clip = SAMPLE_BITS'(SMIN);
         y_sat  = 1'b1;
      end else begin
         y_clip = y[SAMPLE_BITS-1:0];
         y_sat  = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (p3_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_last_ff) begin
         rsp_sample_ff  <= y_clip;
         rsp_channel_ff <= row_ff;
         rsp_sat_ff     <= y_sat;
         rsp_last_ff    <= row_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_sample  = rsp_sample_ff;
   assign rsp.out_channel = rsp_channel_ff;
   assign rsp.saturated   = rsp_sat_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import acmm_pkg::*;

   localparam int MAXCH   = MAX_CHANNELS_DEF;
   localparam int SMP_W   = SAMPLE_BITS_DEF;
   localparam int CF_W    = COEF_BITS_DEF;
   localparam int OUT_LIM = (MAXCH < OUT_MAX) ? MAXCH : OUT_MAX;

   localparam int ITEM_GOAL        = 380;
   localparam int QUIET_CYCLES     = 40;    // settling time after the last owed sample
   localparam int SINK_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 4000;

   // One request as the sender sees it: either a sample or a coefficient write
   typedef struct {
      logic                    is_coef;
      logic signed [SMP_W-1:0] pcm;
      logic [CH_IDX_W-1:0]     row;
      logic [CH_IDX_W-1:0]     col;
      logic signed [CF_W-1:0]  gain;
   } mix_req_type;

   // One mixed output sample as the block should deliver it
   typedef struct {
      logic [SMP_W-1:0]    pcm;
      logic [CH_IDX_W-1:0] chan;
      logic                clipped;
      logic                is_last;
   } mixed_out_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   csr_idx_type          csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   acmm_req_if #(.SAMPLE_BITS(SMP_W), .COEF_BITS(CF_W)) req_ch ();
   acmm_rsp_if #(.SAMPLE_BITS(SMP_W))                   rsp_ch ();

   audio_channel_mix_matrix_unit #(
      .MAX_CHANNELS(MAXCH),
      .SAMPLE_BITS (SMP_W),
      .COEF_BITS   (CF_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Requests still to be offered, and mixed samples still owed by the block
   mix_req_type   req_backlog[$];
   mixed_out_type mixed_due[$];
   int         queued_items = 0;
   int         mix_errors   = 0;

   // Shadow of the block: coefficient matrix, frame being gathered, channel counts
   logic signed [CF_W-1:0]  gain_matrix [MAXCH][MAXCH];
   logic signed [SMP_W-1:0] frame_pcm   [MAXCH];
   int                      fill_pos;
   logic [CFG_W-1:0]        in_ch_cfg;
   logic [CFG_W-1:0]        out_ch_cfg;

   // Traffic shaping
   bit calm_run      = 1'b0;   // no random idling on either side while set
   bit sink_hold_req = 1'b0;   // ask the receiver for its one long hold-off
   bit sink_hold_done = 1'b0;
   int sink_hold_left;
   int idle_cycles;

   // Clock: 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Effective channel count: zero acts as one, anything above the limit as the limit
   function automatic int clamp_count(logic [CFG_W-1:0] v, int hi);
      if (v == 0)
         return 1;
      if (v > hi)
         return hi;
      return v;
   endfunction

   // Apply one accepted request to the shadow state; on a completed frame, work out
   // every mixed sample and queue it as owed
   task automatic apply_mix_request(mix_req_type r);
      int         n_in, n_out, ro, c;
      longint     acc, y;
      mixed_out_type m;
      if (r.is_coef) begin
         gain_matrix[r.row][r.col] = r.gain;
         return;
      end
      n_in = clamp_count(in_ch_cfg, MAXCH);
      if (fill_pos >= n_in)
         fill_pos = 0;
      frame_pcm[fill_pos] = r.pcm;
      fill_pos++;
      if (fill_pos < n_in)
         return;
      fill_pos = 0;
      n_out = clamp_count(out_ch_cfg, OUT_LIM);
      for (ro = 0; ro < n_out; ro++) begin
         acc = 0;
         for (c = 0; c < n_in; c++)
            acc += longint'(frame_pcm[c]) * longint'(gain_matrix[ro][c]);
         // Round half up to Q1.23, then clip to the sample range
         y = (acc + (longint'(1) << (CF_W - 3))) >>> (CF_W - 2);
         m.clipped = 1'b0;
         if (y > (longint'(1) << (SMP_W - 1)) - 1) begin
            y = (longint'(1) << (SMP_W - 1)) - 1;
            m.clipped = 1'b1;
         end else if (y < -(longint'(1) << (SMP_W - 1))) begin
            y = -(longint'(1) << (SMP_W - 1));
            m.clipped = 1'b1;
         end
         m.pcm     = y[SMP_W-1:0];
         m.chan    = ro[CH_IDX_W-1:0];
         m.is_last = (ro + 1 == n_out);
         mixed_due.push_back(m);
      end
   endtask

   // Sample values: extremes, small values near zero, or anything at all
   function automatic logic signed [SMP_W-1:0] pick_pcm();
      case ($urandom_range(5))
         0:       return {1'b0, {(SMP_W-1){1'b1}}};
         1:       return {1'b1, {(SMP_W-1){1'b0}}};
         2:       return SMP_W'($signed($urandom_range(0, 1023)) - 512);
         default: return SMP_W'($urandom);
      endcase
   endfunction

   // Coefficients: extremes, zero, unity, small, or anything at all
   function automatic logic signed [CF_W-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return {1'b0, {(CF_W-1){1'b1}}};
         1:       return {1'b1, {(CF_W-1){1'b0}}};
         2:       return '0;
         3:       return CF_W'(1 << (CF_W - 2));
         4:       return CF_W'($signed($urandom_range(0, 255)) - 128);
         default: return CF_W'($urandom);
      endcase
   endfunction

   // A sample request; the coefficient fields carry noise, since the block ignores them
   function automatic mix_req_type pcm_req(logic signed [SMP_W-1:0] v);
      mix_req_type r;
      r.is_coef = 1'b0;
      r.pcm     = v;
      r.row     = CH_IDX_W'($urandom);
      r.col     = CH_IDX_W'($urandom);
      r.gain    = CF_W'($urandom);
      return r;
   endfunction

   // A coefficient write; the sample field carries noise
   function automatic mix_req_type gain_req(int row, int col, logic signed [CF_W-1:0] g);
      mix_req_type r;
      r.is_coef = 1'b1;
      r.pcm     = SMP_W'($urandom);
      r.row     = CH_IDX_W'(row);
      r.col     = CH_IDX_W'(col);
      r.gain    = g;
      return r;
   endfunction

   // Mostly hit the part of the matrix that the current frame shape uses
   function automatic mix_req_type active_gain(int n_in, int n_out);
      if ($urandom_range(4) != 0)
         return gain_req($urandom_range(n_out - 1), $urandom_range(n_in - 1), pick_gain());
      return gain_req($urandom_range(OUT_MAX - 1), $urandom_range(OUT_MAX - 1), pick_gain());
   endfunction

   task automatic enqueue(mix_req_type r);
      req_backlog.push_back(r);
      queued_items++;
   endtask

   // Hold the sender until every owed sample is in, then let the block settle, since a
   // coefficient write or a partial frame may still be on its way through
   task automatic wait_drained();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_ch.valid || mixed_due.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // Write one register; a write to either register restarts the frame
   task automatic write_reg(csr_idx_type idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IN_CHANNELS)
         in_ch_cfg = val;
      else
         out_ch_cfg = val;
      fill_pos = 0;
   endtask

   // One phase: drain, reprogram both counts, then queue whole frames with coefficient
   // writes before and inside them; optionally leave a partial frame hanging so that the
   // next register write has to restart it
   task automatic run_phase(int in_val, int out_val, int frames, bit hold_sink, bit partial);
      int n_in, n_out, f, k;
      wait_drained();
      write_reg(CSR_IN_CHANNELS, CFG_W'(in_val));
      write_reg(CSR_OUT_CHANNELS, CFG_W'(out_val));
      @(negedge clock);
      if (hold_sink)
         sink_hold_req = 1'b1;
      n_in  = clamp_count(in_ch_cfg, MAXCH);
      n_out = clamp_count(out_ch_cfg, OUT_LIM);
      for (f = 0; f < frames; f++) begin
         repeat ($urandom_range(0, 3)) enqueue(active_gain(n_in, n_out));
         for (k = 0; k < n_in; k++) begin
            if ($urandom_range(7) == 0)
               enqueue(active_gain(n_in, n_out));
            enqueue(pcm_req(pick_pcm()));
         end
      end
      if (partial && n_in > 1)
         repeat ($urandom_range(1, n_in - 1)) enqueue(pcm_req(pick_pcm()));
   endtask

   // Sender: offer the backlog, hold each request until it is taken, idle now and then
   always @(posedge clock) begin : drive_req
      mix_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_backlog.size() != 0 && (calm_run || $urandom_range(99) >= 11)) begin
            nxt = req_backlog.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.req_type   <= nxt.is_coef ? REQ_COEF : REQ_SAMPLE;
            req_ch.sample     <= nxt.pcm;
            req_ch.coef_row   <= nxt.row;
            req_ch.coef_col   <= nxt.col;
            req_ch.coef_value <= nxt.gain;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall now and then, and once hold off for a long stretch so that the
   // block backs up and stops taking requests
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         sink_hold_left <= 0;
      end else if (sink_hold_req && !sink_hold_done) begin
         sink_hold_done <= 1'b1;
         sink_hold_left <= SINK_HOLD_CYCLES;
         rsp_ch.ready   <= 1'b0;
      end else if (sink_hold_left > 0) begin
         sink_hold_left <= sink_hold_left - 1;
         rsp_ch.ready   <= 1'b0;
      end else begin
         rsp_ch.ready <= calm_run || ($urandom_range(99) >= 11);
      end
   end

   // Monitor: check every delivered sample against the oldest one owed, and feed every
   // accepted request to the shadow state
   always @(posedge clock) begin : watch
      mixed_out_type due;
      mix_req_type   seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (mixed_due.size() == 0) begin
               $error("out_channel: expected nothing, got %0d", rsp_ch.out_channel);
               mix_errors++;
            end else begin
               due = mixed_due.pop_front();
               if (rsp_ch.out_sample !== due.pcm) begin
                  $error("out_sample: expected %0d, got %0d",
                         $signed(due.pcm), $signed(rsp_ch.out_sample));
                  mix_errors++;
               end
               if (rsp_ch.out_channel !== due.chan) begin
                  $error("out_channel: expected %0d, got %0d", due.chan, rsp_ch.out_channel);
                  mix_errors++;
               end
               if (rsp_ch.saturated !== due.clipped) begin
                  $error("saturated: expected %0d, got %0d", due.clipped, rsp_ch.saturated);
                  mix_errors++;
               end
               if (rsp_ch.last !== due.is_last) begin
                  $error("last: expected %0d, got %0d", due.is_last, rsp_ch.last);
                  mix_errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.is_coef = (req_ch.req_type == REQ_COEF);
            seen.pcm     = req_ch.sample;
            seen.row     = req_ch.coef_row;
            seen.col     = req_ch.coef_col;
            seen.gain    = req_ch.coef_value;
            apply_mix_request(seen);
         end
      end
   end

   // Watchdog: give up when nothing has moved for far too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int ph_in, ph_out, ph_frames, i, j;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_IN_CHANNELS;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_SAMPLE;
      req_ch.sample     = '0;
      req_ch.coef_row   = '0;
      req_ch.coef_col   = '0;
      req_ch.coef_value = '0;
      rsp_ch.ready      = 1'b0;
      idle_cycles       = 0;

      // Shadow state after reset: empty matrix, two in, two out, frame restarted
      for (i = 0; i < MAXCH; i++) begin
         frame_pcm[i] = '0;
         for (j = 0; j < MAXCH; j++)
            gain_matrix[i][j] = '0;
      end
      fill_pos   = 0;
      in_ch_cfg  = CFG_W'(2);
      out_ch_cfg = CFG_W'(2);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, at the reset counts of two in and two out.
      // Extreme coefficients, unity, zero, and the far corner of the matrix.
      enqueue(gain_req(0, 0, 16'sh7fff));
      enqueue(gain_req(0, 1, 16'sh8000));
      enqueue(gain_req(1, 0, 16'sh4000));
      enqueue(gain_req(1, 1, 16'sh0000));
      enqueue(gain_req(15, 15, 16'shffff));
      // Clip high on row 0, pass-through on row 1
      enqueue(pcm_req(24'sh7fffff));
      enqueue(pcm_req(24'sh800000));
      // Clip low
      enqueue(pcm_req(24'sh800000));
      enqueue(pcm_req(24'sh7fffff));
      // Silence
      enqueue(pcm_req(24'sh000000));
      enqueue(pcm_req(24'sh000000));
      // Half an LSB: rounds up for a positive sum, to zero for a negative one
      enqueue(gain_req(1, 0, 16'sh2000));
      enqueue(pcm_req(24'sh000001));
      enqueue(pcm_req(24'sh000000));
      enqueue(pcm_req(24'shffffff));
      // Coefficient write in the middle of a frame counts for that frame
      enqueue(gain_req(0, 0, 16'sh0000));
      enqueue(pcm_req(24'sh000000));
      enqueue(pcm_req(24'shfffffd));
      enqueue(pcm_req(24'sh000005));
      // Leave half a frame behind for the next register write to discard
      enqueue(pcm_req(24'sh123456));

      // Zero counts act as one in, one out
      run_phase(0, 0, 24, 1'b0, 1'b0);
      // Widest frame
      run_phase(16, 16, 3, 1'b0, 1'b1);
      // Counts above the limit act as the limit
      run_phase(31, 17, 2, 1'b0, 1'b1);
      // Mono to sixteen with the receiver holding off: the block backs up
      run_phase(1, 16, 12, 1'b1, 1'b0);
      // Sixteen down to one, without any idling on either side
      calm_run = 1'b1;
      run_phase(16, 1, 4, 1'b0, 1'b1);
      wait_drained();
      calm_run = 1'b0;

      // Random shapes, mostly small, until the item budget is spent
      while (queued_items < ITEM_GOAL) begin
         case ($urandom_range(9))
            0:       ph_in = $urandom_range(0, 31);
            1:       ph_in = $urandom_range(7, 16);
            default: ph_in = $urandom_range(1, 6);
         endcase
         case ($urandom_range(9))
            0:       ph_out = $urandom_range(0, 31);
            1:       ph_out = $urandom_range(7, 16);
            default: ph_out = $urandom_range(1, 6);
         endcase
         ph_frames = (clamp_count(CFG_W'(ph_in), MAXCH) > 6) ? 2 : $urandom_range(3, 8);
         run_phase(ph_in, ph_out, ph_frames, 1'b0, $urandom_range(3) == 0);
      end

      // Drain, let the block settle, then report
      wait_drained();
      if (mix_errors == 0 && mixed_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
